### rtl/core/ahoc_pkg.sv
// Shared types and codes of the multi-pattern string matcher.
// Used by the front end, the back end and the top level; depends on nothing.
`timescale 1ns / 1ps
package ahoc_pkg;

  // Opcodes carried on the input tuser.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_BUILD   = 2'd2;
  localparam logic [1:0] OP_TEXT    = 2'd3;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  localparam logic [7:0] LETTER_BASE = 8'd97;
  localparam logic [7:0] SPACE_BYTE  = 8'd32;
  localparam int         MAX_RESULTS = 16;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] letter;     // byte minus the letter base
    logic       is_letter;
    logic       is_space;
    logic       end_mark;
  } cmd_t;

endpackage

### rtl/core/ahoc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for every table of the matcher; no dependencies.
`timescale 1ns / 1ps
module ahoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ahoc_front.sv
// Front end: takes input transactions, classifies the byte and queues commands.
// Depends on ahoc_pkg.
`timescale 1ns / 1ps
module ahoc_front #(
  parameter int ALPHABET = 26
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // char_byte
  input  logic [1:0]    s_tuser,   // opcode
  input  logic          s_tlast,   // pattern_end
  input  logic          hold,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output ahoc_pkg::cmd_t cmd
);
  import ahoc_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  cmd_t             q [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QAW:0]     cnt;
  cmd_t             incoming;
  logic             push;
  logic             pop;

  // Classify the byte once, on the way in.
  always_comb begin
    incoming.op        = s_tuser;
    incoming.letter    = s_tdata - LETTER_BASE;
    incoming.is_letter = (s_tdata >= LETTER_BASE) && (incoming.letter < 8'(ALPHABET));
    incoming.is_space  = (s_tdata == SPACE_BYTE);
    incoming.end_mark  = s_tlast;
  end

  assign s_tready  = (cnt < (QAW+1)'(QDEPTH)) && !hold;
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (cnt != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  // Command queue between the two halves.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        q[wp] <= incoming;
        wp    <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

### rtl/core/ahoc_back.sv
// Back end: sequencer that builds the trie and automaton and scans text.
// Depends on ahoc_pkg and ahoc_ram (goto, failure, output mask, queue tables).
`timescale 1ns / 1ps
module ahoc_back #(
  parameter int STATES        = 512,
  parameter int ALPHABET      = 26,
  parameter int PATTERNS      = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ahoc_pkg::cmd_t cmd,
  output logic           sweeping,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);
  import ahoc_pkg::*;

  localparam int NW  = $clog2(STATES);
  localparam int NCW = $clog2(STATES + 1);
  localparam int CW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int GD  = STATES * ALPHABET;
  localparam int GAW = $clog2(GD);
  localparam int PCW = $clog2(PATTERNS + 1);
  localparam int PIW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam logic [31:0] POS_MASK = 32'((64'd1 << POSITION_BITS) - 64'd1);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_SWEEP      = 5'd1;
  localparam logic [4:0] S_PRD        = 5'd2;
  localparam logic [4:0] S_PDATA      = 5'd3;
  localparam logic [4:0] S_PEND       = 5'd4;
  localparam logic [4:0] S_PMASK_WR   = 5'd5;
  localparam logic [4:0] S_BROOT_RD   = 5'd6;
  localparam logic [4:0] S_BROOT_DATA = 5'd7;
  localparam logic [4:0] S_BQ_RD      = 5'd8;
  localparam logic [4:0] S_BQ_DATA    = 5'd9;
  localparam logic [4:0] S_BFAIL_DATA = 5'd10;
  localparam logic [4:0] S_BE_ADDR    = 5'd11;
  localparam logic [4:0] S_BE_RD      = 5'd12;
  localparam logic [4:0] S_BE_DATA    = 5'd13;
  localparam logic [4:0] S_BLINK      = 5'd14;
  localparam logic [4:0] S_BMASK_FL   = 5'd15;
  localparam logic [4:0] S_BMASK_CH   = 5'd16;
  localparam logic [4:0] S_BDONE      = 5'd17;
  localparam logic [4:0] S_TBAD       = 5'd18;
  localparam logic [4:0] S_TMASK_RD   = 5'd19;
  localparam logic [4:0] S_TMASK_DATA = 5'd20;
  localparam logic [4:0] S_TEMIT      = 5'd21;
  localparam logic [4:0] S_W0         = 5'd22;
  localparam logic [4:0] S_W1         = 5'd23;
  localparam logic [4:0] S_W2         = 5'd24;
  localparam logic [4:0] S_W3         = 5'd25;

  logic [4:0]              state;
  logic [4:0]              ret_state;
  logic [GAW-1:0]          sw;
  logic [NCW-1:0]          node_count;
  logic [PCW-1:0]          pattern_count;
  logic [NW-1:0]           cursor;
  logic [NW-1:0]           cur_len;
  logic                    dropped;
  logic                    ovf;
  logic [NW-1:0]           search;
  logic [POSITION_BITS-1:0] tpos;
  logic [POSITION_BITS-1:0] pos;
  logic [NW-1:0]           plen [PATTERNS];
  logic                    endm;
  logic [CW-1:0]           bc;
  logic [NCW-1:0]          head;
  logic [NCW-1:0]          tail;
  logic [NW-1:0]           bs;
  logic [NW-1:0]           bfs;
  logic [NW-1:0]           bchild;
  logic [PATTERNS-1:0]     mfl;
  logic [NW-1:0]           wcur;
  logic [CW-1:0]           wc;
  logic [NCW-1:0]          wn;
  logic [NW-1:0]           wres;
  logic [GAW-1:0]          gaddr;
  logic [PATTERNS-1:0]     rem;
  logic [3:0]              nres;

  // Result register.
  logic                    res_valid;
  logic [1:0]              res_kind;
  logic [3:0]              res_idx;
  logic [15:0]             res_start;
  logic [15:0]             res_end;
  logic [9:0]              res_total;
  logic                    res_ovf;
  logic                    res_last;

  // Table ports.
  logic                    g_we;
  logic [GAW-1:0]          g_waddr;
  logic [NW:0]             g_wdata;
  logic [GAW-1:0]          g_raddr;
  logic [NW:0]             g_rdata;
  logic                    f_we;
  logic [NW-1:0]           f_waddr;
  logic [NW-1:0]           f_wdata;
  logic [NW-1:0]           f_raddr;
  logic [NW-1:0]           f_rdata;
  logic                    mk_we;
  logic [NW-1:0]           mk_waddr;
  logic [PATTERNS-1:0]     mk_wdata;
  logic [NW-1:0]           mk_raddr;
  logic [PATTERNS-1:0]     mk_rdata;
  logic                    q_we;
  logic [NW-1:0]           q_waddr;
  logic [NW-1:0]           q_wdata;
  logic [NW-1:0]           q_raddr;
  logic [NW-1:0]           q_rdata;

  logic                    g_v;
  logic [NW-1:0]           g_child;
  logic                    out_free;
  logic                    node_room;
  logic                    queue_room;
  logic [PATTERNS-1:0]     cntmask;
  logic [PATTERNS-1:0]     pbit;
  logic [PIW-1:0]          jsel;
  logic [PATTERNS-1:0]     rem_next;
  logic [31:0]             start32;
  logic [31:0]             pos32;

  ahoc_ram #(.WIDTH(NW + 1), .DEPTH(GD)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );
  ahoc_ram #(.WIDTH(NW), .DEPTH(STATES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );
  ahoc_ram #(.WIDTH(PATTERNS), .DEPTH(STATES)) u_mask (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_rdata)
  );
  ahoc_ram #(.WIDTH(NW), .DEPTH(STATES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign g_v        = g_rdata[NW];
  assign g_child    = g_rdata[NW-1:0];
  assign out_free   = !res_valid || m_tready;
  assign node_room  = (node_count < NCW'(STATES));
  assign queue_room = (tail < NCW'(STATES));
  assign cmd_ready  = (state == S_IDLE);
  assign sweeping   = (state == S_SWEEP);

  // Patterns that are loaded so far, and the bit of the pattern in progress.
  always_comb begin
    for (int j = 0; j < PATTERNS; j++) begin
      cntmask[j] = (PCW'(j) < pattern_count);
    end
    pbit = PATTERNS'(1) << pattern_count;
  end

  // Lowest pending match and its start position.
  always_comb begin
    jsel = '0;
    for (int j = PATTERNS - 1; j >= 0; j--) begin
      if (rem[j]) begin
        jsel = PIW'(j);
      end
    end
    rem_next = rem & ~(PATTERNS'(1) << jsel);
    pos32    = 32'(pos);
    start32  = (pos32 + 32'd1 - 32'(plen[jsel])) & POS_MASK;
  end

  // Table port control for each sequencer step.
  always_comb begin
    g_we     = 1'b0;
    g_waddr  = gaddr;
    g_wdata  = '0;
    g_raddr  = gaddr;
    f_we     = 1'b0;
    f_waddr  = bchild;
    f_wdata  = wres;
    f_raddr  = wcur;
    mk_we    = 1'b0;
    mk_waddr = cursor;
    mk_wdata = '0;
    mk_raddr = cursor;
    q_we     = 1'b0;
    q_waddr  = tail[NW-1:0];
    q_wdata  = bchild;
    q_raddr  = head[NW-1:0];
    unique case (state)
      S_SWEEP: begin
        g_we     = 1'b1;
        g_waddr  = sw;
        mk_we    = (sw < GAW'(STATES));
        mk_waddr = sw[NW-1:0];
      end
      S_PDATA: begin
        if (!g_v && node_room) begin
          g_we    = 1'b1;
          g_wdata = {1'b1, NW'(node_count)};
        end
      end
      S_PMASK_WR: begin
        mk_we    = 1'b1;
        mk_wdata = mk_rdata | pbit;
      end
      S_BROOT_RD: begin
        g_raddr = GAW'(bc);
      end
      S_BROOT_DATA: begin
        if (!g_v) begin
          g_we    = 1'b1;
          g_waddr = GAW'(bc);
          g_wdata = {1'b1, NW'(0)};
        end else if (g_child != '0 && queue_room) begin
          f_we    = 1'b1;
          f_waddr = g_child;
          f_wdata = '0;
          q_we    = 1'b1;
          q_wdata = g_child;
        end
      end
      S_BQ_DATA: begin
        f_raddr = q_rdata;
      end
      S_BLINK: begin
        f_we     = 1'b1;
        mk_raddr = wres;
      end
      S_BMASK_FL: begin
        mk_raddr = bchild;
      end
      S_BMASK_CH: begin
        mk_we    = 1'b1;
        mk_waddr = bchild;
        mk_wdata = mk_rdata | mfl;
        q_we     = queue_room;
      end
      S_TMASK_RD: begin
        mk_raddr = wres;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SWEEP;
      sw            <= '0;
      node_count    <= NCW'(1);
      pattern_count <= '0;
      cursor        <= '0;
      cur_len       <= '0;
      dropped       <= 1'b0;
      ovf           <= 1'b0;
      search        <= '0;
      tpos          <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && m_tready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_CLEAR: begin
                state         <= S_SWEEP;
                sw            <= '0;
                node_count    <= NCW'(1);
                pattern_count <= '0;
                cursor        <= '0;
                cur_len       <= '0;
                dropped       <= 1'b0;
                ovf           <= 1'b0;
                search        <= '0;
                tpos          <= '0;
              end
              OP_PATTERN: begin
                endm <= cmd.end_mark;
                if (pattern_count >= PCW'(PATTERNS)) begin
                  ovf <= 1'b1;
                end else if (!dropped && cmd.is_letter) begin
                  gaddr <= GAW'(cursor) * GAW'(ALPHABET) + GAW'(cmd.letter[CW-1:0]);
                  state <= S_PRD;
                end else begin
                  if (!dropped) begin
                    ovf <= 1'b1;
                  end
                  state <= S_PEND;
                end
              end
              OP_BUILD: begin
                bc    <= '0;
                tail  <= '0;
                state <= S_BROOT_RD;
              end
              OP_TEXT: begin
                pos  <= tpos;
                tpos <= tpos + 1'b1;
                if (cmd.is_space) begin
                  state <= S_IDLE;
                end else if (!cmd.is_letter) begin
                  search <= '0;
                  state  <= S_TBAD;
                end else begin
                  wcur      <= search;
                  wc        <= cmd.letter[CW-1:0];
                  wn        <= '0;
                  ret_state <= S_TMASK_RD;
                  state     <= S_W0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Clearing pass over the goto and output mask tables.
        S_SWEEP: begin
          if (sw == GAW'(GD - 1)) begin
            state <= S_IDLE;
          end else begin
            sw <= sw + 1'b1;
          end
        end
        // Pattern insertion.
        S_PRD: begin
          state <= S_PDATA;
        end
        S_PDATA: begin
          if (g_v || node_room) begin
            if (g_v) begin
              cursor <= g_child;
            end else begin
              cursor     <= NW'(node_count);
              node_count <= node_count + 1'b1;
            end
            if (cur_len < NW'(STATES - 1)) begin
              cur_len <= cur_len + 1'b1;
            end
          end else begin
            ovf     <= 1'b1;
            dropped <= 1'b1;
          end
          state <= S_PEND;
        end
        S_PEND: begin
          if (!endm) begin
            state <= S_IDLE;
          end else if (!dropped && cur_len != '0) begin
            state <= S_PMASK_WR;
          end else begin
            ovf           <= 1'b1;
            pattern_count <= pattern_count + 1'b1;
            cursor        <= '0;
            cur_len       <= '0;
            dropped       <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_PMASK_WR: begin
          plen[pattern_count[PIW-1:0]] <= cur_len;
          pattern_count <= pattern_count + 1'b1;
          cursor        <= '0;
          cur_len       <= '0;
          dropped       <= 1'b0;
          state         <= S_IDLE;
        end
        // Build: root self-loops and first level.
        S_BROOT_RD: begin
          state <= S_BROOT_DATA;
        end
        S_BROOT_DATA: begin
          if (g_v && g_child != '0 && queue_room) begin
            tail <= tail + 1'b1;
          end
          if (bc == CW'(ALPHABET - 1)) begin
            head  <= '0;
            state <= S_BQ_RD;
          end else begin
            bc    <= bc + 1'b1;
            state <= S_BROOT_RD;
          end
        end
        // Build: breadth-first pass over the queue.
        S_BQ_RD: begin
          if (head < tail) begin
            head  <= head + 1'b1;
            state <= S_BQ_DATA;
          end else begin
            state <= S_BDONE;
          end
        end
        S_BQ_DATA: begin
          bs    <= q_rdata;
          state <= S_BFAIL_DATA;
        end
        S_BFAIL_DATA: begin
          bfs   <= f_rdata;
          bc    <= '0;
          state <= S_BE_ADDR;
        end
        S_BE_ADDR: begin
          gaddr <= GAW'(bs) * GAW'(ALPHABET) + GAW'(bc);
          state <= S_BE_RD;
        end
        S_BE_RD: begin
          state <= S_BE_DATA;
        end
        S_BE_DATA: begin
          if (g_v) begin
            bchild    <= g_child;
            wcur      <= bfs;
            wc        <= bc;
            wn        <= '0;
            ret_state <= S_BLINK;
            state     <= S_W0;
          end else if (bc == CW'(ALPHABET - 1)) begin
            state <= S_BQ_RD;
          end else begin
            bc    <= bc + 1'b1;
            state <= S_BE_ADDR;
          end
        end
        S_BLINK: begin
          state <= S_BMASK_FL;
        end
        S_BMASK_FL: begin
          mfl   <= mk_rdata;
          state <= S_BMASK_CH;
        end
        S_BMASK_CH: begin
          if (queue_room) begin
            tail <= tail + 1'b1;
          end
          if (bc == CW'(ALPHABET - 1)) begin
            state <= S_BQ_RD;
          end else begin
            bc    <= bc + 1'b1;
            state <= S_BE_ADDR;
          end
        end
        S_BDONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_kind  <= KIND_BUILD;
            res_idx   <= '0;
            res_start <= '0;
            res_end   <= '0;
            res_total <= 10'(node_count);
            res_ovf   <= ovf;
            res_last  <= 1'b1;
            cursor    <= '0;
            cur_len   <= '0;
            dropped   <= 1'b0;
            search    <= '0;
            tpos      <= '0;
            state     <= S_IDLE;
          end
        end
        // Text scan.
        S_TBAD: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_kind  <= KIND_BAD;
            res_idx   <= '0;
            res_start <= '0;
            res_end   <= pos32[15:0];
            res_total <= '0;
            res_ovf   <= 1'b0;
            res_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_TMASK_RD: begin
          search <= wres;
          state  <= S_TMASK_DATA;
        end
        S_TMASK_DATA: begin
          rem  <= mk_rdata & cntmask;
          nres <= '0;
          if ((mk_rdata & cntmask) == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_TEMIT;
          end
        end
        S_TEMIT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            res_kind  <= KIND_MATCH;
            res_idx   <= 4'(jsel);
            res_start <= start32[15:0];
            res_end   <= pos32[15:0];
            res_total <= '0;
            res_ovf   <= 1'b0;
            res_last  <= (rem_next == '0) || (nres == 4'(MAX_RESULTS - 1));
            rem       <= rem_next;
            nres      <= nres + 1'b1;
            if ((rem_next == '0) || (nres == 4'(MAX_RESULTS - 1))) begin
              state <= S_IDLE;
            end
          end
        end
        // Shared walk along failure links until an edge on the letter exists.
        S_W0: begin
          gaddr <= GAW'(wcur) * GAW'(ALPHABET) + GAW'(wc);
          state <= S_W1;
        end
        S_W1: begin
          state <= S_W2;
        end
        S_W2: begin
          if (g_v) begin
            wres  <= g_child;
            state <= ret_state;
          end else if (wcur == '0 || wn == NCW'(STATES)) begin
            wres  <= '0;
            state <= ret_state;
          end else begin
            wn    <= wn + 1'b1;
            state <= S_W3;
          end
        end
        S_W3: begin
          wcur  <= f_rdata;
          state <= S_W0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_kind;
  assign m_tlast  = res_last;
  assign m_tdata  = {1'b0, res_ovf, res_total, res_end, res_start, res_idx};

  // A clear transaction always starts a fresh clearing pass.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == OP_CLEAR) |=> (state == S_SWEEP && sw == '0))
    else $error("clear did not start a clearing pass");

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= NCW'(STATES) && node_count != '0)
    else $error("node count out of range");

  a_pattern_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_count <= PCW'(PATTERNS))
    else $error("pattern count out of range");

  // A match burst never reports more results than allowed.
  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEMIT && out_free && nres == 4'(MAX_RESULTS - 1)) |=> (state == S_IDLE))
    else $error("match burst exceeded its limit");

endmodule

### rtl/core/aho_corasick_multi_pattern_matcher_unit.sv
// Top level of the multi-pattern string matcher.
// Depends on ahoc_pkg, ahoc_front and ahoc_back (which holds the tables).
//
//  channel | direction | tdata                       | tuser   | tlast
//  s_      | in        | char_byte                   | opcode  | pattern_end
//  m_      | out       | index/start/end/total/ovf   | kind    | last
//
// Reset and clear both run a clearing pass over the goto and output mask
// tables, during which s_tready is low. The command queue of four entries
// and the result register let either side stall without stopping the other
// until the queue is full.
`timescale 1ns / 1ps
module aho_corasick_multi_pattern_matcher_unit #(
  parameter int STATES        = 512,
  parameter int ALPHABET      = 26,
  parameter int PATTERNS      = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte
  input  logic [1:0]  s_tuser,   // opcode
  input  logic        s_tlast,   // pattern_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // pattern_index[3:0], match_start[19:4], match_end[35:20],
  // node_total[45:36], capacity_overflow[46], zero[47]
  output logic [47:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);
  import ahoc_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic sweeping;

  ahoc_front #(.ALPHABET(ALPHABET)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .hold(sweeping),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  ahoc_back #(
    .STATES(STATES), .ALPHABET(ALPHABET),
    .PATTERNS(PATTERNS), .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .sweeping(sweeping),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule
